// ===== rtl/core/tmv_pkg.sv =====
// Shared types and constants for the tiled map viewport block.
`timescale 1ns / 1ps

package tmv_pkg;

  // Tile geometry: the tile edge is a power of two, 256 pixels.
  localparam int TILE_LOG2 = 8;
  localparam int TILE_SIZE = 1 << TILE_LOG2;

  // Zoom limits.
  localparam logic [4:0] MAX_ZOOM      = 5'd22;
  localparam logic [4:0] ZOOM_FROM_MIN = 5'd2;
  localparam logic [4:0] ZOOM_OUT_MIN  = 5'd1;

  // Field widths.
  localparam int OFF_W   = 32;
  localparam int TILE_W  = 24;
  localparam int COUNT_W = 9;
  localparam int ZOOM_W  = 5;
  localparam int WRAP_W  = 30;
  localparam int OP_W    = 3;
  localparam int IN_W    = 72;
  localparam int OUT_W   = 136;

  // Operation codes; code 7 is unused and changes nothing.
  typedef enum logic [2:0] {
    OP_INIT      = 3'd0,
    OP_MOVE      = 3'd1,
    OP_ZOOM_AT   = 3'd2,
    OP_ZOOM_FROM = 3'd3,
    OP_ZOOM_IN   = 3'd4,
    OP_ZOOM_OUT  = 3'd5,
    OP_RESIZE    = 3'd6
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic report;
  } tmv_cmd_t;

endpackage

// ===== rtl/core/tmv_dp.sv =====
// Datapath: captured operation, viewport state and result register.
`timescale 1ns / 1ps

module tmv_dp import tmv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  tmv_cmd_t         cmd,
  input  logic [OP_W-1:0]  in_op,
  input  logic [IN_W-1:0]  in_data,
  output logic [OUT_W-1:0] out_data
);

  // Truncating halving of a signed 32-bit value.
  function automatic logic [31:0] half32(input logic [31:0] v);
    logic [31:0] s;
    begin
      s = v + {31'b0, v[31]};
      return {s[31], s[31:1]};
    end
  endfunction

  // (offset - size/2)/2 with a 32-bit wrap.
  function automatic logic [31:0] half_back(input logic [31:0] off, input logic [15:0] size);
    logic [31:0] d;
    begin
      d = off - {17'b0, size[15:1]};
      return half32(d);
    end
  endfunction

  // Half of (old size - new size), truncated, sign extended to 32 bits.
  function automatic logic [31:0] half_diff(input logic [15:0] old_sz, input logic [15:0] new_sz);
    logic [16:0] dw;
    logic [16:0] hd;
    begin
      dw = {1'b0, old_sz} - {1'b0, new_sz};
      hd = dw + {16'b0, dw[16]};
      return {{15{hd[16]}}, hd[16], hd[16:1]};
    end
  endfunction

  // Operation captured on the input transfer.
  logic [2:0]  op_r;
  logic [15:0] sx_r, sy_r, nw_r, nh_r;
  logic [4:0]  zl_r;

  // Viewport state.
  logic [31:0] off_x_r, off_y_r, off_x_nxt, off_y_nxt;
  logic [4:0]  zoom_r, zoom_nxt;
  logic [15:0] width_r, height_r, width_nxt, height_nxt;

  // Result fields.
  logic [31:0] bias_x, bias_y, tx, ty, wmask;
  logic [5:0]  wshift;
  logic [15:0] w_sh, h_sh;
  logic [OUT_W-1:0] out_r, out_nxt;

  // Input capture register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_op;
      sx_r <= in_data[15:0];
      sy_r <= in_data[31:16];
      nw_r <= in_data[47:32];
      nh_r <= in_data[63:48];
      zl_r <= in_data[68:64];
    end
  end

  // Next state for each operation.
  always_comb begin
    off_x_nxt  = off_x_r;
    off_y_nxt  = off_y_r;
    zoom_nxt   = zoom_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    case (op_r)
      OP_INIT: begin
        width_nxt  = nw_r;
        height_nxt = nh_r;
        zoom_nxt   = (zl_r > MAX_ZOOM) ? MAX_ZOOM : zl_r;
        off_x_nxt  = '0;
        off_y_nxt  = '0;
      end
      OP_MOVE: begin
        off_x_nxt = off_x_r + {{16{sx_r[15]}}, sx_r};
        off_y_nxt = off_y_r + {{16{sy_r[15]}}, sy_r};
      end
      OP_ZOOM_AT: begin
        if (zoom_r < MAX_ZOOM) begin
          zoom_nxt  = zoom_r + 5'd1;
          off_x_nxt = {off_x_r[30:0], 1'b0} + {{16{sx_r[15]}}, sx_r};
          off_y_nxt = {off_y_r[30:0], 1'b0} + {{16{sy_r[15]}}, sy_r};
        end
      end
      OP_ZOOM_IN: begin
        if (zoom_r < MAX_ZOOM) begin
          zoom_nxt  = zoom_r + 5'd1;
          off_x_nxt = {off_x_r[30:0], 1'b0} + {17'b0, width_r[15:1]};
          off_y_nxt = {off_y_r[30:0], 1'b0} + {17'b0, height_r[15:1]};
        end
      end
      OP_ZOOM_FROM: begin
        if (zoom_r > ZOOM_FROM_MIN) begin
          zoom_nxt  = zoom_r - 5'd1;
          off_x_nxt = half_back(off_x_r, width_r) - {{16{sx_r[15]}}, sx_r};
          off_y_nxt = half_back(off_y_r, height_r) - {{16{sy_r[15]}}, sy_r};
        end
      end
      OP_ZOOM_OUT: begin
        if (zoom_r > ZOOM_OUT_MIN) begin
          zoom_nxt  = zoom_r - 5'd1;
          off_x_nxt = half_back(off_x_r, width_r);
          off_y_nxt = half_back(off_y_r, height_r);
        end
      end
      OP_RESIZE: begin
        off_x_nxt  = off_x_r + half_diff(width_r, nw_r);
        off_y_nxt  = off_y_r + half_diff(height_r, nh_r);
        width_nxt  = nw_r;
        height_nxt = nh_r;
      end
      default: begin
      end
    endcase
  end

  // Viewport state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r  <= '0;
      off_y_r  <= '0;
      zoom_r   <= '0;
      width_r  <= '0;
      height_r <= '0;
    end else if (cmd.exec) begin
      off_x_r  <= off_x_nxt;
      off_y_r  <= off_y_nxt;
      zoom_r   <= zoom_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // Result fields from the updated state. Negative offsets are biased so that
  // the shift truncates toward zero; the wrap is a mask since the world size
  // is a power of two.
  always_comb begin
    bias_x = off_x_r[31] ? 32'(TILE_SIZE - 1) : 32'd0;
    bias_y = off_y_r[31] ? 32'(TILE_SIZE - 1) : 32'd0;
    tx     = off_x_r + bias_x;
    ty     = off_y_r + bias_y;
    w_sh   = width_r >> TILE_LOG2;
    h_sh   = height_r >> TILE_LOG2;
    wshift = 6'(TILE_LOG2) + {1'b0, zoom_r};
    wmask  = (32'd1 << wshift) - 32'd1;
    out_nxt = {5'b0,
               off_y_r[WRAP_W-1:0] & wmask[WRAP_W-1:0],
               off_x_r[WRAP_W-1:0] & wmask[WRAP_W-1:0],
               zoom_r,
               h_sh[COUNT_W-1:0] + 9'd1,
               w_sh[COUNT_W-1:0] + 9'd1,
               ty[TILE_LOG2 +: TILE_W],
               tx[TILE_LOG2 +: TILE_W]};
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.report) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

// ===== rtl/core/tmv_ctrl.sv =====
// Controller: sequences capture, state update and result load per operation.
`timescale 1ns / 1ps

module tmv_ctrl import tmv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output tmv_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_EXEC   = 3'b010,
    ST_REPORT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The result register is free when empty or being taken this cycle.
  assign out_free = !out_valid_r || out_tready;

  // Commands and next state.
  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.report  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_REPORT;
      end
      ST_REPORT: begin
        if (out_free) begin
          cmd.report = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.report) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

`ifndef ASSERT_OFF
  // An accepted operation always goes straight to its state update.
  a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.exec)
    else $error("capture not followed by state update");

  // A state update is always followed by the result load phase.
  a_exec_report: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> (state_r == ST_REPORT))
    else $error("state update not followed by result phase");

  // A result is loaded only when the previous one is gone or leaving.
  a_report_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.report |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

  // Loading a result raises valid on the next cycle.
  a_report_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.report |=> out_tvalid)
    else $error("loaded result not presented");
`endif

endmodule

// ===== rtl/core/tile_map_viewport_pan_zoom.sv =====
// Top level of the tiled map viewport pan and zoom block.
`timescale 1ns / 1ps
//
// Channel | Direction | Ports                          | Payload
// --------+-----------+--------------------------------+------------------------
// in      | slave     | in_tvalid, in_tready,          | one viewport operation
//         |           | in_tuser, in_tdata             |
// out     | master    | out_tvalid, out_tready,        | viewport report, one
//         |           | out_tdata                      | per operation
//
// Each operation passes in turn through input capture, state update and result load.
// A stalled result register holds the block in the result phase; no new
// operation is taken until the result is loaded, but one is taken while the
// previous result still waits to be transferred.
// Synchronous active-low reset clears the viewport state to zero.

module tile_map_viewport_pan_zoom import tmv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // op[2:0]
  input  logic [OP_W-1:0]  in_tuser,
  // shift_x[15:0], shift_y[31:16], view_width[47:32], view_height[63:48],
  // zoom_level[68:64], zero pad[71:69]
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // first_tile_x[23:0], first_tile_y[47:24], tiles_across[56:48],
  // tiles_down[65:57], zoom_now[70:66], wrapped_x[100:71],
  // wrapped_y[130:101], zero pad[135:131]
  output logic [OUT_W-1:0] out_tdata
);

  tmv_cmd_t cmd;

  tmv_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  tmv_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_op    (in_tuser),
    .in_data  (in_tdata),
    .out_data (out_tdata)
  );

endmodule

// ===== tb/tmv_checker.sv =====
// Checker for the viewport block: predicts each viewport report and compares it.
`timescale 1ns / 1ps

module tmv_checker import tmv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  // op[2:0]
  input  logic [OP_W-1:0]  in_tuser,
  // shift_x[15:0], shift_y[31:16], view_width[47:32], view_height[63:48],
  // zoom_level[68:64], zero pad[71:69]
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  // first_tile_x[23:0], first_tile_y[47:24], tiles_across[56:48],
  // tiles_down[65:57], zoom_now[70:66], wrapped_x[100:71],
  // wrapped_y[130:101], zero pad[135:131]
  input  logic [OUT_W-1:0] out_tdata,
  output int               fail_count,
  output int               pending_cnt
);

  typedef struct packed {
    logic [TILE_W-1:0]  tile_x;
    logic [TILE_W-1:0]  tile_y;
    logic [COUNT_W-1:0] across;
    logic [COUNT_W-1:0] down;
    logic [ZOOM_W-1:0]  zoom;
    logic [WRAP_W-1:0]  wrap_x;
    logic [WRAP_W-1:0]  wrap_y;
  } view_report_t;

  // Reports predicted for operations already transferred, oldest first.
  view_report_t viewport_reports[$];

  // Predicted viewport state.
  int               vp_off_x;
  int               vp_off_y;
  logic [4:0]       vp_zoom;
  logic [15:0]      vp_width;
  logic [15:0]      vp_height;

  int               errs = 0;
  view_report_t     new_rep;
  view_report_t     exp_rep;

  // (offset - size/2)/2; int arithmetic wraps at 32 bits and truncates toward zero.
  function automatic int halve_toward_centre(int off, logic [15:0] size);
    int d;
    d = off - int'(size >> 1);
    return d / 2;
  endfunction

  // Offset taken non-negatively modulo one turn of the world at this zoom.
  function automatic logic [WRAP_W-1:0] wrap_world(int off, logic [4:0] z);
    longint m;
    longint r;
    m = longint'(TILE_SIZE) << z;
    r = longint'(off) % m;
    if (r < 0) begin
      r = r + m;
    end
    return r[WRAP_W-1:0];
  endfunction

  function automatic int field_mismatch(string name, longint unsigned exp_v,
                                        longint unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  // Applies one operation to the predicted state and forms the report it causes.
  task automatic advance_viewport(input logic [OP_W-1:0] op, input logic [IN_W-1:0] item,
                                  output view_report_t rep);
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic [15:0]        nw;
    logic [15:0]        nh;
    logic [4:0]         zl;
    int                 px;
    int                 py;
    int                 t;
    sx = item[15:0];
    sy = item[31:16];
    nw = item[47:32];
    nh = item[63:48];
    zl = item[68:64];
    px = sx;
    py = sy;
    case (op)
      OP_INIT: begin
        vp_width  = nw;
        vp_height = nh;
        vp_zoom   = (zl > MAX_ZOOM) ? MAX_ZOOM : zl;
        vp_off_x  = 0;
        vp_off_y  = 0;
      end
      OP_MOVE: begin
        vp_off_x = vp_off_x + px;
        vp_off_y = vp_off_y + py;
      end
      OP_ZOOM_AT, OP_ZOOM_IN: begin
        // Zooming in on the centre uses half the view size as the point.
        if (op == OP_ZOOM_IN) begin
          px = int'(vp_width >> 1);
          py = int'(vp_height >> 1);
        end
        if (vp_zoom < MAX_ZOOM) begin
          vp_zoom  = vp_zoom + 5'd1;
          vp_off_x = vp_off_x * 2 + px;
          vp_off_y = vp_off_y * 2 + py;
        end
      end
      OP_ZOOM_FROM: begin
        if (vp_zoom > ZOOM_FROM_MIN) begin
          vp_zoom  = vp_zoom - 5'd1;
          vp_off_x = halve_toward_centre(vp_off_x, vp_width) - px;
          vp_off_y = halve_toward_centre(vp_off_y, vp_height) - py;
        end
      end
      OP_ZOOM_OUT: begin
        if (vp_zoom > ZOOM_OUT_MIN) begin
          vp_zoom  = vp_zoom - 5'd1;
          vp_off_x = halve_toward_centre(vp_off_x, vp_width);
          vp_off_y = halve_toward_centre(vp_off_y, vp_height);
        end
      end
      OP_RESIZE: begin
        vp_off_x  = vp_off_x + (int'(vp_width) - int'(nw)) / 2;
        vp_off_y  = vp_off_y + (int'(vp_height) - int'(nh)) / 2;
        vp_width  = nw;
        vp_height = nh;
      end
      default: begin
        // The unused code leaves the viewport as it is.
      end
    endcase

    t           = vp_off_x / TILE_SIZE;
    rep.tile_x  = t[TILE_W-1:0];
    t           = vp_off_y / TILE_SIZE;
    rep.tile_y  = t[TILE_W-1:0];
    t           = int'(vp_width) / TILE_SIZE + 1;
    rep.across  = t[COUNT_W-1:0];
    t           = int'(vp_height) / TILE_SIZE + 1;
    rep.down    = t[COUNT_W-1:0];
    rep.zoom    = vp_zoom;
    rep.wrap_x  = wrap_world(vp_off_x, vp_zoom);
    rep.wrap_y  = wrap_world(vp_off_y, vp_zoom);
  endtask

  // Watch both channels; an operation is predicted as soon as it is transferred.
  always @(posedge clk) begin
    if (!rst_n) begin
      vp_off_x  = 0;
      vp_off_y  = 0;
      vp_zoom   = '0;
      vp_width  = '0;
      vp_height = '0;
      viewport_reports.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        advance_viewport(in_tuser, in_tdata, new_rep);
        viewport_reports.push_back(new_rep);
      end
      if (out_tvalid && out_tready) begin
        if (viewport_reports.size() == 0) begin
          $error("viewport report 0x%0h arrived with none expected", out_tdata);
          errs++;
        end else begin
          exp_rep = viewport_reports.pop_front();
          errs += field_mismatch("first_tile_x", exp_rep.tile_x, out_tdata[23:0]);
          errs += field_mismatch("first_tile_y", exp_rep.tile_y, out_tdata[47:24]);
          errs += field_mismatch("tiles_across", exp_rep.across, out_tdata[56:48]);
          errs += field_mismatch("tiles_down", exp_rep.down, out_tdata[65:57]);
          errs += field_mismatch("zoom_now", exp_rep.zoom, out_tdata[70:66]);
          errs += field_mismatch("wrapped_x", exp_rep.wrap_x, out_tdata[100:71]);
          errs += field_mismatch("wrapped_y", exp_rep.wrap_y, out_tdata[130:101]);
        end
      end
    end
    fail_count  <= errs;
    pending_cnt <= viewport_reports.size();
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the viewport block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import tmv_pkg::*;

  // Operation code that the block does not use.
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 1600;
  localparam int HOLD_CYCLES  = 400;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic [OP_W-1:0]  in_tuser   = '0;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             out_tready = 1'b0;
  logic             in_tready;
  logic             out_tvalid;
  logic [OUT_W-1:0] out_tdata;
  int               fail_count;
  int               pending_cnt;

  // no_idle and hold_req are shared between the sender and the receiver; sent counts operations sent.
  bit               no_idle  = 1'b0;
  bit               hold_req = 1'b0;
  int               sent     = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tile_map_viewport_pan_zoom dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  tmv_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .pending_cnt (pending_cnt)
  );

  // Offers one operation after a random gap and waits for its transfer.
  task automatic send_op(input logic [2:0] op, input logic [15:0] sx, input logic [15:0] sy,
                         input logic [15:0] w, input logic [15:0] h, input logic [4:0] zl);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, zl, h, w, sy, sx};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // Stops offering and waits until every predicted report has been transferred.
  task automatic drain_reports();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
  endtask

  // Pan delta or anchor point: extremes, small values or anything.
  function automatic logic [15:0] pick_shift();
    case ($urandom_range(0, 5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return 16'($urandom_range(0, 511)) - 16'd256;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_size();
    if ($urandom_range(0, 1) == 0) begin
      return 16'($urandom_range(0, 2047));
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  // Receiver: random stalls per report, plus one long hold-off on request.
  initial begin
    int gap;
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Stimulus and verdict.
  initial begin
    int  kind;
    int  n;
    int  target;
    bit  held;
    bit  paused;
    logic [2:0] op;
    held   = 1'b0;
    paused = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: field extremes, every operation and each limit.
    send_op(OP_UNUSED, 16'h1234, 16'hFEDC, 16'hFFFF, 16'hFFFF, 5'd31);
    send_op(OP_INIT, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 5'd31);
    send_op(OP_ZOOM_AT, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 5'd0);
    send_op(OP_ZOOM_IN, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 5'd0);
    send_op(OP_MOVE, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 5'd0);
    send_op(OP_MOVE, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 5'd0);
    send_op(OP_ZOOM_OUT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 5'd0);
    send_op(OP_ZOOM_FROM, 16'd100, 16'hFF9C, 16'h0000, 16'h0000, 5'd0);
    send_op(OP_RESIZE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 5'd0);
    send_op(OP_RESIZE, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 5'd0);
    send_op(OP_INIT, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 5'd0);
    send_op(OP_ZOOM_OUT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 5'd0);
    send_op(OP_ZOOM_FROM, 16'h0001, 16'h0001, 16'h0000, 16'h0000, 5'd0);
    send_op(OP_ZOOM_AT, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 5'd0);
    send_op(OP_ZOOM_OUT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 5'd0);
    send_op(OP_ZOOM_IN, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 5'd0);
    send_op(OP_ZOOM_FROM, 16'h0003, 16'h0003, 16'h0000, 16'h0000, 5'd0);
    send_op(OP_ZOOM_AT, 16'h0005, 16'hFFFB, 16'h0000, 16'h0000, 5'd0);
    send_op(OP_ZOOM_FROM, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 5'd0);
    send_op(OP_MOVE, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 5'd0);
    send_op(OP_MOVE, 16'h8000, 16'h0101, 16'h0000, 16'h0000, 5'd0);
    send_op(OP_INIT, 16'h0000, 16'h0000, 16'd300, 16'd511, 5'd22);
    send_op(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31);
    send_op(OP_RESIZE, 16'h0000, 16'h0000, 16'd301, 16'd510, 5'd0);
    send_op(OP_RESIZE, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 5'd0);
    drain_reports();

    // Random part: mostly sessions that start with init, some deep zoom
    // chains that overflow the offsets, and some fully random noise.
    target = sent + RANDOM_ITEMS;
    while (sent < target) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if (!held && sent > target - RANDOM_ITEMS + 400) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      if (!paused && sent > target - RANDOM_ITEMS + 900) begin
        drain_reports();
        paused = 1'b1;
      end
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        send_op(OP_INIT, pick_shift(), pick_shift(), pick_size(), pick_size(),
                ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(0, 22)));
        n = $urandom_range(5, 20);
        repeat (n) begin
          op = 3'($urandom_range(OP_MOVE, OP_RESIZE));
          send_op(op, pick_shift(), pick_shift(), pick_size(), pick_size(),
                  5'($urandom_range(0, 31)));
        end
      end else if (kind <= 7) begin
        send_op(OP_INIT, 16'h0000, 16'h0000, pick_size(), pick_size(),
                5'($urandom_range(0, 2)));
        n = $urandom_range(18, 24);
        repeat (n) begin
          op = ($urandom_range(0, 2) == 0) ? OP_ZOOM_IN : OP_ZOOM_AT;
          send_op(op, pick_shift(), pick_shift(), pick_size(), pick_size(),
                  5'($urandom_range(0, 31)));
        end
        n = $urandom_range(2, 8);
        repeat (n) begin
          op = ($urandom_range(0, 1) == 0) ? OP_ZOOM_OUT : OP_ZOOM_FROM;
          send_op(op, pick_shift(), pick_shift(), pick_size(), pick_size(),
                  5'($urandom_range(0, 31)));
        end
      end else begin
        n = $urandom_range(3, 8);
        repeat (n) begin
          send_op(3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 5'($urandom_range(0, 31)));
        end
      end
    end

    // Let the last reports arrive, then keep watching for any stray one.
    no_idle = 1'b0;
    drain_reports();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
